/* design/crc16sgc_pkg.sv */
// Package for the CRC-16 stream generator and checker.
// Holds the generator constant, the stage item type and the byte update function.
// No dependencies.
`default_nettype none

package crc16sgc_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned CRC_W  = 16;

   localparam logic [CRC_W-1:0] CRC_SEED_CONST = 16'hDCF2;
   localparam logic [CRC_W-1:0] CRC_GEN_LOW    = {CRC_SEED_CONST[CRC_W-2:0], 1'b0};

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
   } stage_item_type;

   function automatic logic [CRC_W-1:0] crc_feed_byte(
      input logic [CRC_W-1:0]  rem,
      input logic [DATA_W-1:0] data
   );
      logic [CRC_W-1:0] r;
      r = rem ^ {data, {(CRC_W-DATA_W){1'b0}}};
      for (int k = 0; k < DATA_W; k++) begin
         if (r[CRC_W-1]) begin
            r = {r[CRC_W-2:0], 1'b0} ^ CRC_GEN_LOW;
         end else begin
            r = {r[CRC_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/crc16sgc_if.sv */
// Valid/ready channel interfaces for message bytes and CRC results.
// Depends on crc16sgc_pkg.
`default_nettype none

interface crc16sgc_req_if
   import crc16sgc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16sgc_rsp_if
   import crc16sgc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] remainder;
   logic             check_ok;

   modport source (output valid, output remainder, output check_ok, input ready);
   modport sink   (input valid, input remainder, input check_ok, output ready);
endinterface

`default_nettype wire

/* design/crc16sgc_in_stage.sv */
// Input register stage: captures one byte beat and holds it until the CRC stage takes it.
// Depends on crc16sgc_pkg and crc16sgc_req_if.
`default_nettype none

module crc16sgc_in_stage
   import crc16sgc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   crc16sgc_req_if.sink        req,
   input  wire logic           drain,
   output stage_item_type      item
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff;
   logic              last_ff;
   logic              accept;

   assign req.ready = !valid_ff || drain;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req.data_byte;
         last_ff <= req.last_byte;
      end
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = data_ff;
   assign item.last_byte = last_ff;

endmodule

`default_nettype wire

/* design/crc16sgc_crc_stage.sv */
// CRC stage: running remainder, byte update and the result register.
// Depends on crc16sgc_pkg and crc16sgc_rsp_if.
`default_nettype none

module crc16sgc_crc_stage
   import crc16sgc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stage_item_type item,
   output logic                drain,
   crc16sgc_rsp_if.source      rsp
);

   logic [CRC_W-1:0] rem_ff, rem_in;
   logic [CRC_W-1:0] rem_next;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_rem_ff;
   logic             rsp_ok_ff;
   logic             fire;
   logic             emit;

   // A byte that is not last never needs the result register.
   assign drain    = !item.last_byte || !rsp_valid_ff || rsp.ready;
   assign fire     = item.valid && drain;
   assign emit     = fire && item.last_byte;
   assign rem_next = crc_feed_byte(rem_ff, item.data_byte);

   always_comb begin
      if (!fire) begin
         rem_in = rem_ff;
      end else if (item.last_byte) begin
         rem_in = '0;
      end else begin
         rem_in = rem_next;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_rem_ff <= rem_next;
         rsp_ok_ff  <= (rem_next == '0);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.remainder = rsp_rem_ff;
   assign rsp.check_ok  = rsp_ok_ff;

endmodule

`default_nettype wire

/* design/crc16_stream_generate_check_unit.sv */
// Top level of the CRC-16 stream generator and checker (MSB first, zero seed).
// Depends on crc16sgc_pkg, crc16sgc_if, crc16sgc_in_stage and crc16sgc_crc_stage.
//
//   Channel   Direction  Beat contents
//   req_bus   in         data_byte[7:0], last_byte
//   rsp_bus   out        remainder[15:0], check_ok (one beat per last byte)
//
// One byte is accepted per cycle unless a stalled result holds back a last byte.
// Throughput is set by the single byte update between the input and result registers.
// Reset clears the running remainder and both valid flags; no clearing pass is needed.
// A stalled result blocks the next last byte and all bytes behind it; earlier ones still flow.
`default_nettype none

module crc16_stream_generate_check_unit
   import crc16sgc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   crc16sgc_req_if.sink    req_bus,
   crc16sgc_rsp_if.source  rsp_bus
);

   stage_item_type stage_item;
   logic           stage_drain;

   crc16sgc_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .drain (stage_drain),
      .item  (stage_item)
   );

   crc16sgc_crc_stage u_crc_stage (
      .clock (clock),
      .reset (reset),
      .item  (stage_item),
      .drain (stage_drain),
      .rsp   (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_ok_matches_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.check_ok == (rsp_bus.remainder == '0)))
      else $error("check_ok disagrees with the remainder");

   a_blocked_last_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (stage_item.valid && stage_item.last_byte && !stage_drain) |-> !req_bus.ready)
      else $error("input accepted while a last byte is blocked");

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (stage_item.valid && stage_item.last_byte && stage_drain) |=> rsp_bus.valid)
      else $error("last byte taken without a result");
`endif

endmodule

`default_nettype wire
